### hw/rtl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned SUM_W  = 16;
   localparam int unsigned REQ_W  = 32;

   localparam logic [SUM_W-1:0] COMM_ID_RESET = 16'd312;

   // Which byte of the frame the emitter drives next.
   typedef enum logic [8:0] {
      K_TYPE   = 9'b000000001,
      K_ID_LO  = 9'b000000010,
      K_ID_HI  = 9'b000000100,
      K_LEN_LO = 9'b000001000,
      K_LEN_HI = 9'b000010000,
      K_DATA   = 9'b000100000,
      K_PAD    = 9'b001000000,
      K_CK_HI  = 9'b010000000,
      K_CK_LO  = 9'b100000000
   } kind_type;

   // One accepted beat, with its place in the frame already resolved.
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  payload_length;
      logic              first;
      logic              last;
   } item_type;

   // Ones' complement add with end-around carry.
   function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pfc_frame_track.sv
`default_nettype none

module pfc_frame_track (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [pfc_pkg::BYTE_W-1:0]  payload_byte,
   input  wire logic [pfc_pkg::BYTE_W-1:0]  frame_type,
   input  wire logic [pfc_pkg::LEN_W-1:0]   payload_length,
   output pfc_pkg::item_type                item
);

   logic                       inside_ff;
   logic                       inside_in;
   logic [pfc_pkg::LEN_W-1:0]  rem_ff;
   logic [pfc_pkg::LEN_W-1:0]  rem_in;
   logic [pfc_pkg::LEN_W-1:0]  len_eff;
   logic [pfc_pkg::LEN_W-1:0]  rem_cur;

   always_comb begin
      // A zero length counts as one byte.
      len_eff = (payload_length == '0) ? pfc_pkg::LEN_W'(1) : payload_length;
      rem_cur = inside_ff ? rem_ff : len_eff;
      rem_in  = rem_cur - pfc_pkg::LEN_W'(1);

      item.payload_byte   = payload_byte;
      item.frame_type     = frame_type;
      item.payload_length = len_eff;
      item.first          = ~inside_ff;
      item.last           = (rem_in == '0);

      inside_in = ~item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         rem_ff    <= '0;
      end else if (accept) begin
         inside_ff <= inside_in;
         rem_ff    <= rem_in;
      end
   end

   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      inside_ff |-> rem_ff != '0)
      else $error("frame open with no bytes remaining");

endmodule

`default_nettype wire

### hw/rtl/pfc_emitter.sv
`default_nettype none

module pfc_emitter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire pfc_pkg::item_type           item_in,
   input  wire logic [pfc_pkg::SUM_W-1:0]   comm_id,
   output logic                             can_load,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [pfc_pkg::BYTE_W-1:0]       rsp_byte,
   output logic                             rsp_last
);

   pfc_pkg::item_type                item_ff;
   logic                             item_vld_ff;
   pfc_pkg::kind_type                kind_ff;
   pfc_pkg::kind_type                kind_in;
   pfc_pkg::kind_type                kind_start;
   logic                             done;

   logic [pfc_pkg::SUM_W-1:0]        sum_ff;
   logic [pfc_pkg::BYTE_W-1:0]       held_ff;
   logic                             pending_ff;

   logic                             rsp_vld_ff;
   logic [pfc_pkg::BYTE_W-1:0]       rsp_byte_ff;
   logic                             rsp_last_ff;

   logic                             out_free;
   logic                             emit;
   logic                             absorb;
   logic                             ck_lo;
   logic [pfc_pkg::BYTE_W-1:0]       byte_in;

   always_comb begin
      out_free = ~rsp_vld_ff | rsp_ready;
      emit     = item_vld_ff & out_free;
      byte_in  = '0;
      kind_in  = kind_ff;
      done     = 1'b0;
      absorb   = 1'b1;
      ck_lo    = 1'b0;
      unique case (kind_ff)
         pfc_pkg::K_TYPE: begin
            byte_in = item_ff.frame_type;
            kind_in = pfc_pkg::K_ID_LO;
         end
         pfc_pkg::K_ID_LO: begin
            byte_in = comm_id[7:0];
            kind_in = pfc_pkg::K_ID_HI;
         end
         pfc_pkg::K_ID_HI: begin
            byte_in = comm_id[15:8];
            kind_in = pfc_pkg::K_LEN_LO;
         end
         pfc_pkg::K_LEN_LO: begin
            byte_in = item_ff.payload_length[7:0];
            kind_in = pfc_pkg::K_LEN_HI;
         end
         pfc_pkg::K_LEN_HI: begin
            byte_in = item_ff.payload_length[15:8];
            kind_in = pfc_pkg::K_DATA;
         end
         pfc_pkg::K_DATA: begin
            byte_in = item_ff.payload_byte;
            done    = ~item_ff.last;
            // Count goes odd after this byte unless it closes a pair: pad then.
            kind_in = pending_ff ? pfc_pkg::K_CK_HI : pfc_pkg::K_PAD;
         end
         pfc_pkg::K_PAD: begin
            byte_in = '0;
            kind_in = pfc_pkg::K_CK_HI;
         end
         pfc_pkg::K_CK_HI: begin
            byte_in = ~sum_ff[15:8];
            absorb  = 1'b0;
            kind_in = pfc_pkg::K_CK_LO;
         end
         pfc_pkg::K_CK_LO: begin
            byte_in = ~sum_ff[7:0];
            absorb  = 1'b0;
            ck_lo   = 1'b1;
            done    = 1'b1;
         end
         default: begin
            byte_in = '0;
            done    = 1'b1;
            absorb  = 1'b0;
         end
      endcase
      kind_start = item_in.first ? pfc_pkg::K_TYPE : pfc_pkg::K_DATA;
      can_load   = ~item_vld_ff | (emit & done);
   end

   // Current item and its byte sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         kind_ff     <= pfc_pkg::K_DATA;
      end else if (load) begin
         item_vld_ff <= 1'b1;
         kind_ff     <= kind_start;
      end else if (emit & done) begin
         item_vld_ff <= 1'b0;
      end else if (emit) begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   // Running checksum over header, payload and pad.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         pending_ff <= 1'b0;
      end else if (emit & ck_lo) begin
         sum_ff     <= '0;
         pending_ff <= 1'b0;
      end else if (emit & absorb) begin
         if (pending_ff) begin
            sum_ff     <= pfc_pkg::oc_add(sum_ff, {held_ff, byte_in});
            pending_ff <= 1'b0;
         end else begin
            pending_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit & absorb & ~pending_ff) begin
         held_ff <= byte_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= byte_in;
         rsp_last_ff <= ck_lo;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      emit && kind_ff == pfc_pkg::K_CK_LO |=> sum_ff == '0 && !pending_ff)
      else $error("checksum state not cleared at frame end");

   a_pad_only_odd: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && kind_ff == pfc_pkg::K_PAD |-> pending_ff)
      else $error("pad byte with even byte count");

   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      load && item_in.first |-> !pending_ff || (emit && ck_lo))
      else $error("frame starts with a held byte");

endmodule

`default_nettype wire

### hw/rtl/packet_framer_ones_complement_checksum_core.sv
// Channel   Dir  Beat contents
// req_*     in   tdata[7:0] payload_byte, [15:8] frame_type, [31:16] payload_length
// rsp_*     out  tdata[7:0] out_byte, tlast last_of_frame
// csr_*     in   wr_data comm_id, written when wr_en is high
//
// One wire byte leaves per cycle unless rsp_tready stalls, through the single output
// byte register: a mid-frame payload beat yields one byte, a frame's first beat six
// (header plus byte), its last three or four (byte, optional pad, two checksum bytes).
// A new beat is taken in the cycle the previous beat's last byte is registered.
// Reset is synchronous; it empties the pipeline and sets comm_id to 312.
// rsp_tready low holds the output register and stalls the byte sequence.
`default_nettype none

module packet_framer_ones_complement_checksum_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // [7:0] payload_byte, [15:8] frame_type, [31:16] payload_length
   input  wire logic [pfc_pkg::REQ_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [7:0] out_byte
   output logic [pfc_pkg::BYTE_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,
   input  wire logic                       csr_wr_en,
   input  wire logic [pfc_pkg::SUM_W-1:0]  csr_wr_data
);

   logic [pfc_pkg::SUM_W-1:0] comm_id_ff;
   logic                      accept;
   logic                      can_load;
   pfc_pkg::item_type         item;

   always_ff @(posedge clock) begin
      if (reset) begin
         comm_id_ff <= pfc_pkg::COMM_ID_RESET;
      end else if (csr_wr_en) begin
         comm_id_ff <= csr_wr_data;
      end
   end

   assign req_tready = can_load;
   assign accept     = req_tvalid & can_load;

   pfc_frame_track u_track (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .payload_byte   (req_tdata[7:0]),
      .frame_type     (req_tdata[15:8]),
      .payload_length (req_tdata[31:16]),
      .item           (item)
   );

   pfc_emitter u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .item_in   (item),
      .comm_id   (comm_id_ff),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

`default_nettype wire
